// File: sv/swr_pkg.sv
// Shared constants, codes and types of the sliding window receiver.
`default_nettype none
package swr_pkg;
  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int WIN_W       = 6;
  localparam int MAX_PAYLOAD = 1456;
  localparam int QUEUE_DEPTH = 2;
  localparam int SEQ_W       = 32;
  localparam int LEN_W       = 11;
  localparam int TAG_W       = 16;
  localparam int CONN_W      = 16;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_DATA    = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_OPEN     = 2'd1;
  localparam logic [1:0] EV_CLOSE    = 2'd2;
  localparam logic [1:0] EV_RESERVED = 2'd3;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } pkt_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MOD_SEQ, B_MOD_EXP, B_CHECK, B_DELIVER
  } back_state_t;
endpackage
`default_nettype wire

// File: sv/swr_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/swr_mod.sv
// Bit-serial remainder unit: dividend modulo a small divisor, one bit a cycle.
`default_nettype none
module swr_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [swr_pkg::SEQ_W-1:0] dividend,
  input  wire logic [swr_pkg::WIN_W-1:0] divisor,
  output logic                           done,
  output logic [swr_pkg::SLOT_W-1:0]     rem
);
  import swr_pkg::*;

  logic [SEQ_W-1:0]         shreg;
  logic [WIN_W-1:0]         div;
  logic [WIN_W-1:0]         part;
  logic [$clog2(SEQ_W)-1:0] count;
  logic                     running;
  logic [WIN_W:0]           trial;
  logic [WIN_W-1:0]         part_next;

  always_comb begin
    trial = {part, shreg[SEQ_W-1]};
    if (trial >= {1'b0, div}) begin
      part_next = WIN_W'(trial - {1'b0, div});
    end else begin
      part_next = trial[WIN_W-1:0];
    end
  end

  assign rem = part[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == '1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div   <= divisor;
      part  <= '0;
    end else if (running) begin
      shreg <= {shreg[SEQ_W-2:0], 1'b0};
      part  <= part_next;
    end
  end
endmodule
`default_nettype wire

// File: sv/swr_fifo.sv
// Short packet queue between the front and back sections.
`default_nettype none
module swr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire swr_pkg::pkt_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output swr_pkg::pkt_t      pop_data
);
  import swr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pkt_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   fill;

  assign full     = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

// File: sv/swr_front.sv
// Front section: takes input beats and drops packets that can never give a result.
`default_nettype none
module swr_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [63:0]   s_tdata,
  input  wire logic [1:0]    s_tuser,
  input  wire logic          q_full,
  output logic               q_push,
  output swr_pkg::pkt_t      q_data
);
  import swr_pkg::*;

  logic             crc_ok;
  logic [LEN_W-1:0] len;
  logic             keep;

  assign crc_ok = s_tdata[32];
  assign len    = s_tdata[43:33];

  // Unknown commands, bad checksums and oversized payloads are dropped here.
  always_comb begin
    case (s_tuser)
      CMD_START, CMD_END: keep = 1'b1;
      CMD_DATA:           keep = crc_ok && (len <= LEN_W'(MAX_PAYLOAD));
      default:            keep = 1'b0;
    endcase
  end

  assign s_tready   = !q_full;
  assign q_push     = s_tvalid && !q_full && keep;
  assign q_data.cmd = s_tuser;
  assign q_data.seq = s_tdata[31:0];
  assign q_data.len = len;
  assign q_data.tag = s_tdata[59:44];
endmodule
`default_nettype wire

// File: sv/swr_back.sv
// Back section: connection state, slot store, in-order release and result register.
`default_nettype none
module swr_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [swr_pkg::WIN_W-1:0] win,
  input  wire logic                      q_empty,
  input  wire swr_pkg::pkt_t             q_data,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [79:0]                    m_tdata,
  output logic [2:0]                     m_tuser,
  output logic                           m_tlast
);
  import swr_pkg::*;

  back_state_t       state, state_next;
  logic [SEQ_W-1:0]  expected;
  logic [SEQ_W-1:0]  start_number;
  logic              start_seen;
  logic              end_seen;
  logic [CONN_W-1:0] conn;
  logic [SLOT_COUNT-1:0] filled;
  logic [SLOT_W-1:0] k;
  logic [WIN_W-1:0]  cnt;
  logic [TAG_W-1:0]  cur_tag;
  logic [LEN_W-1:0]  cur_len;

  logic              can_load;
  logic              mod_start;
  logic [SEQ_W-1:0]  mod_arg;
  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;
  logic              ram_we;
  logic [TAG_W+LEN_W-1:0] ram_rdata;
  logic              in_window;
  logic              is_old;
  logic              walk_more;
  logic [SLOT_W-1:0] k_next;

  // Result register fields.
  logic              load;
  logic              r_kind;
  logic [SEQ_W-1:0]  r_seq;
  logic [TAG_W-1:0]  r_tag;
  logic [LEN_W-1:0]  r_len;
  logic [1:0]        r_ev;
  logic [CONN_W-1:0] r_conn;
  logic              r_last;

  assign can_load  = !m_tvalid || m_tready;
  assign in_window = ({1'b0, q_data.seq} < ({1'b0, expected} + (SEQ_W+1)'(win)));
  assign is_old    = (q_data.seq < expected);
  assign walk_more = (cnt < win) && filled[k];
  assign k_next    = (({1'b0, k} + 1'b1) == (SLOT_W+1)'(win)) ? '0 : k + 1'b1;

  swr_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_arg),
    .divisor  (win),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  swr_ram #(.WIDTH(TAG_W + LEN_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mod_rem),
    .wdata ({cur_tag, cur_len}),
    .raddr (k),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mod_start  = 1'b0;
    mod_arg    = q_data.seq;
    ram_we     = 1'b0;
    load       = 1'b0;
    r_kind     = KIND_ACK;
    r_seq      = expected;
    r_tag      = '0;
    r_len      = '0;
    r_ev       = EV_NONE;
    r_conn     = conn;
    r_last     = 1'b1;
    case (state)
      B_IDLE: begin
        if (!q_empty && can_load) begin
          q_pop = 1'b1;
          case (q_data.cmd)
            CMD_START: begin
              load  = 1'b1;
              r_seq = q_data.seq;
              r_ev  = start_seen ? EV_NONE : EV_OPEN;
            end
            CMD_END: begin
              load  = 1'b1;
              r_seq = start_number;
              if (!end_seen) begin
                r_ev   = EV_CLOSE;
                r_conn = conn + 1'b1;
              end
            end
            default: begin
              if (in_window && is_old) begin
                load = 1'b1;
              end else if (in_window) begin
                mod_start  = 1'b1;
                state_next = B_MOD_SEQ;
              end
            end
          endcase
        end
      end
      B_MOD_SEQ: begin
        if (mod_done) begin
          ram_we     = 1'b1;
          mod_start  = 1'b1;
          mod_arg    = expected;
          state_next = B_MOD_EXP;
        end
      end
      B_MOD_EXP: begin
        if (mod_done) begin
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        if (walk_more) begin
          state_next = B_DELIVER;
        end else if (can_load) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_DELIVER: begin
        if (can_load) begin
          load       = 1'b1;
          r_kind     = KIND_DELIVER;
          r_tag      = ram_rdata[TAG_W+LEN_W-1:LEN_W];
          r_len      = ram_rdata[LEN_W-1:0];
          r_last     = 1'b0;
          state_next = B_CHECK;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected     <= '0;
      start_number <= '0;
      start_seen   <= 1'b0;
      end_seen     <= 1'b0;
      conn         <= '0;
      filled       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == B_IDLE && q_pop) begin
        if (q_data.cmd == CMD_START) begin
          start_number <= q_data.seq;
          expected     <= '0;
          if (!start_seen) begin
            start_seen <= 1'b1;
            end_seen   <= 1'b0;
          end
        end else if (q_data.cmd == CMD_END && !end_seen) begin
          conn       <= conn + 1'b1;
          end_seen   <= 1'b1;
          start_seen <= 1'b0;
        end
      end
      if (ram_we) begin
        filled[mod_rem] <= 1'b1;
      end
      if (state == B_DELIVER && can_load) begin
        filled[k] <= 1'b0;
        expected  <= expected + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      cur_tag <= q_data.tag;
      cur_len <= q_data.len;
    end
    if (state == B_MOD_EXP && mod_done) begin
      k   <= mod_rem;
      cnt <= '0;
    end else if (state == B_DELIVER && can_load) begin
      k   <= k_next;
      cnt <= cnt + 1'b1;
    end
    if (load) begin
      m_tdata <= {5'd0, r_conn, r_len, r_tag, r_seq};
      m_tuser <= {r_ev, r_kind};
      m_tlast <= r_last;
    end
  end
endmodule
`default_nettype wire

// File: sv/sliding_window_receiver_core.sv
// Top level of the sliding window receiver.
`default_nettype none
// The receiver takes one packet per input beat (START, END or DATA) and gives
// acknowledgment and in-order delivery beats. A front section drops packets that
// can never produce a result (unknown command, bad checksum, oversized payload)
// and places the rest in a two-entry queue; the back section holds the
// connection state and the slot store and drives a result register, so input
// beats keep being taken while a result waits downstream, until the queue is
// full. START and END packets and old DATA are answered straight from the
// idle state. An in-window DATA packet has its slot index, and then the slot
// of the window start, found by a bit-serial remainder unit; then every
// released slot takes one slot-store read and one delivery beat before the
// closing acknowledgment. The window register may only be written while the
// block is idle; a value of zero acts as one and a value above 32 acts as 32.
module sliding_window_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,  // receive window length
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,    // seq_num, crc_ok, payload_len, payload_tag
  input  wire logic [1:0]  s_tuser,    // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,    // seq_value, out_tag, out_len, connection
  output logic [2:0]       m_tuser,    // kind[0], file_event[2:1]
  output logic             m_tlast     // last
);
  import swr_pkg::*;

  logic [WIN_W-1:0] win_cfg;
  logic [WIN_W-1:0] win;
  logic             q_full;
  logic             q_push;
  pkt_t             q_in;
  logic             q_pop;
  logic             q_empty;
  pkt_t             q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= WINDOW_RESET;
    end else if (cfg_we) begin
      win_cfg <= cfg_wdata;
    end
  end

  // Effective window: zero is raised to one, and values above the built slot count are clamped to it.
  always_comb begin
    if (win_cfg == '0) begin
      win = WIN_W'(1);
    end else if (win_cfg > WIN_W'(SLOT_COUNT)) begin
      win = WIN_W'(SLOT_COUNT);
    end else begin
      win = win_cfg;
    end
  end

  swr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  swr_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  swr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .win      (win),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );
endmodule
`default_nettype wire

// File: sv/swr_checker.sv
// Port-level checks of the sliding window receiver, bound to the top level.
`default_nettype none
module swr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  import swr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == KIND_DELIVER) |-> !m_tlast)
    else $error("delivery marked as final result");

  a_deliver_no_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == KIND_DELIVER) |-> (m_tuser[2:1] == EV_NONE))
    else $error("delivery carries a file event");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:1] != EV_RESERVED))
    else $error("illegal file event code");
endmodule

bind sliding_window_receiver_core swr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
